### hw/rtl/ptlb_pkg.sv
// ----------------------------------------------------------------------------
// ptlb_pkg: shared types and constants for the page translation unit
// Fixed field widths, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package ptlb_pkg;

	localparam int OP_W       = 2;
	localparam int ADDR_W     = 24;
	localparam int FRAME_IN_W = 10;
	localparam int PHYS_W     = 22;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 32;

	typedef enum logic [OP_W-1:0] {
		OP_TRANSLATE = 2'd0,
		OP_MAP       = 2'd1,
		OP_UNMAP     = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NOT_MAPPED = 2'd1,
		ST_ALREADY    = 2'd2,
		ST_RESERVED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_REM,
		S_TLB,
		S_DONE
	} state_t;

endpackage

### hw/rtl/ptlb_req_if.sv
// ----------------------------------------------------------------------------
// ptlb_req_if: request channel of the page translation unit
// Valid/ready handshake carrying one operation on one virtual page.
// ----------------------------------------------------------------------------
interface ptlb_req_if;
	import ptlb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [ADDR_W-1:0]     vaddr;
	logic [FRAME_IN_W-1:0] frame_number;

	modport source (output valid, operation, vaddr, frame_number, input ready);
	modport sink   (input valid, operation, vaddr, frame_number, output ready);
endinterface

### hw/rtl/ptlb_rsp_if.sv
// ----------------------------------------------------------------------------
// ptlb_rsp_if: result channel of the page translation unit
// Valid/ready handshake carrying one result item per request.
// ----------------------------------------------------------------------------
interface ptlb_rsp_if;
	import ptlb_pkg::*;

	logic                valid;
	logic                ready;
	logic [PHYS_W-1:0]   paddr;
	logic [STATUS_W-1:0] status;
	logic                tlb_hit;
	logic [COUNT_W-1:0]  access_count;
	logic [COUNT_W-1:0]  miss_count;

	modport source (output valid, paddr, status, tlb_hit, access_count, miss_count,
		input ready);
	modport sink   (input valid, paddr, status, tlb_hit, access_count, miss_count,
		output ready);
endinterface

### hw/rtl/page_translate_with_tlb_unit.sv
// ----------------------------------------------------------------------------
// page_translate_with_tlb_unit: page table with a direct-mapped TLB
// Translate, map and unmap of virtual pages; access and miss counters.
// ----------------------------------------------------------------------------
// Usage notes.
// req channel: one item = operation, vaddr, frame_number. Accepted on a
//   clock edge with req.valid and req.ready high.
// rsp channel: one item per request = paddr, status, tlb_hit and the two
//   counters as they stand after that request.
// Steps: page table read and quotient multiply in the accepting cycle
//   (S_IDLE), remainder in S_REM (page number modulo TLB_SLOTS by
//   reciprocal multiply and one correction), correction and TLB read in
//   S_TLB, then the decision and write-back to both memories in S_DONE,
//   which waits while the output register holds an untaken result.
//   Requests are taken only in S_IDLE, so one item is worked on at a time.
// Reset: arst_n clears the controller and counters, then a clearing pass
//   writes zero to every page table and TLB entry, one per cycle.
//   req.ready stays low during the pass.
// Stall: the result sits in an output register. The next request is taken
//   while it waits; that request only completes once the result is taken.
// ----------------------------------------------------------------------------
module page_translate_with_tlb_unit #(
	parameter int OFFSET_WIDTH = 12,
	parameter int VPAGE_WIDTH  = 12,
	parameter int FRAME_WIDTH  = 10,
	parameter int TLB_SLOTS    = 64
) (
	input logic        clk,
	input logic        arst_n,
	ptlb_req_if.sink   req,
	ptlb_rsp_if.source rsp
);
	import ptlb_pkg::*;

	// derived sizes
	localparam int PAGES  = 1 << VPAGE_WIDTH;
	localparam int SLOT_W = $clog2(TLB_SLOTS);
	localparam int VA_W   = (OFFSET_WIDTH + VPAGE_WIDTH > ADDR_W) ?
		OFFSET_WIDTH + VPAGE_WIDTH : ADDR_W;
	localparam int FR_W   = (FRAME_WIDTH > FRAME_IN_W) ? FRAME_WIDTH : FRAME_IN_W;
	localparam int PX_W   = (FRAME_WIDTH + OFFSET_WIDTH > PHYS_W) ?
		FRAME_WIDTH + OFFSET_WIDTH : PHYS_W;
	localparam int REM_W  = (VPAGE_WIDTH > SLOT_W) ? VPAGE_WIDTH + 1 : SLOT_W + 1;
	localparam int PROD_W = 2 * VPAGE_WIDTH;
	localparam int PT_W   = FRAME_WIDTH + 1;
	localparam int TLB_W  = 1 + VPAGE_WIDTH + FRAME_WIDTH;
	localparam int NMAX   = (PAGES > TLB_SLOTS) ? PAGES : TLB_SLOTS;
	localparam int CLR_W  = $clog2(NMAX) + 1;

	// floor(2**V / slots): quotient estimate is low by at most one
	localparam logic [VPAGE_WIDTH-1:0] RECIP = VPAGE_WIDTH'(PAGES / TLB_SLOTS);
	localparam logic [REM_W-1:0]       D_REM = REM_W'(TLB_SLOTS);

	// controller and counters
	state_t               state_q, state_d;
	logic [CLR_W-1:0]     clr_q;
	logic [COUNT_W-1:0]   acc_q, acc_d;
	logic [COUNT_W-1:0]   miss_q, miss_d;
	logic                 rsp_valid_q;

	// captured request
	logic [OP_W-1:0]        op_q;
	logic [VPAGE_WIDTH-1:0] vpn_q;
	logic [OFFSET_WIDTH-1:0] off_q;
	logic [FRAME_WIDTH-1:0] frame_in_q;

	// slot arithmetic
	logic [PROD_W-1:0]      prod_q;
	logic [REM_W-1:0]       rem_q;
	logic [REM_W-1:0]       rem_fix;
	logic [SLOT_W-1:0]      slot_q;
	logic [SLOT_W-1:0]      slot_c;

	// request decode
	logic [VA_W-1:0]        va_ext;
	logic [FR_W-1:0]        fi_ext;
	logic [VPAGE_WIDTH-1:0] req_vpn;
	logic                   accept;
	logic                   req_ready;

	// memories
	logic [PT_W-1:0]        pt_mem [PAGES];
	logic [TLB_W-1:0]       tlb_mem [TLB_SLOTS];
	logic [PT_W-1:0]        pt_rd_q;
	logic [TLB_W-1:0]       tlb_rd_q;
	logic                   pt_re, pt_we, tlb_re, tlb_we;
	logic [VPAGE_WIDTH-1:0] pt_wa;
	logic [SLOT_W-1:0]      tlb_wa;
	logic [PT_W-1:0]        pt_wd;
	logic [TLB_W-1:0]       tlb_wd;

	// lookup decode
	logic                   pt_valid, tlb_valid, tlb_match, vpn_zero;
	logic [FRAME_WIDTH-1:0] pt_frame, tlb_frame;
	logic [VPAGE_WIDTH-1:0] tlb_tag;
	logic [PX_W-1:0]        px_hit, px_fill;

	// result
	logic                   done_go;
	logic [PHYS_W-1:0]      res_phys, phys_q;
	status_t                res_status, status_q;
	logic                   res_hit, hit_q;

	assign va_ext  = VA_W'(req.vaddr);
	assign fi_ext  = FR_W'(req.frame_number);
	assign req_vpn = va_ext[OFFSET_WIDTH +: VPAGE_WIDTH];
	assign req.ready = req_ready;
	assign accept  = req.valid && req_ready;

	// remainder lands below twice the slot count: one compare and subtract
	assign rem_fix = (rem_q >= D_REM) ? rem_q - D_REM : rem_q;
	assign slot_c  = rem_fix[SLOT_W-1:0];

	assign pt_valid  = pt_rd_q[FRAME_WIDTH];
	assign pt_frame  = pt_rd_q[FRAME_WIDTH-1:0];
	assign tlb_valid = tlb_rd_q[TLB_W-1];
	assign tlb_tag   = tlb_rd_q[FRAME_WIDTH +: VPAGE_WIDTH];
	assign tlb_frame = tlb_rd_q[FRAME_WIDTH-1:0];
	assign tlb_match = tlb_valid && (tlb_tag == vpn_q);
	assign vpn_zero  = (vpn_q == '0);
	assign px_hit    = PX_W'({tlb_frame, off_q});
	assign px_fill   = PX_W'({pt_frame, off_q});

	// page table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pt_we)
			pt_mem[pt_wa] <= pt_wd;
		if (pt_re)
			pt_rd_q <= pt_mem[req_vpn];
	end

	// TLB entry = valid, tag, frame
	always_ff @(posedge clk) begin
		if (tlb_we)
			tlb_mem[tlb_wa] <= tlb_wd;
		if (tlb_re)
			tlb_rd_q <= tlb_mem[slot_c];
	end

	// request capture and slot pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.operation;
			vpn_q      <= req_vpn;
			off_q      <= va_ext[OFFSET_WIDTH-1:0];
			frame_in_q <= fi_ext[FRAME_WIDTH-1:0];
			prod_q     <= PROD_W'(req_vpn) * PROD_W'(RECIP);
		end
		if (state_q == S_REM)
			rem_q <= REM_W'(vpn_q) - REM_W'(prod_q[PROD_W-1:VPAGE_WIDTH]) * D_REM;
		if (state_q == S_TLB)
			slot_q <= slot_c;
		if (done_go) begin
			phys_q   <= res_phys;
			status_q <= res_status;
			hit_q    <= res_hit;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			acc_q       <= '0;
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			miss_q  <= miss_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + CLR_W'(1);
			if (done_go)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// next state, memory controls and result
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		pt_re      = 1'b0;
		tlb_re     = 1'b0;
		pt_we      = 1'b0;
		pt_wa      = vpn_q;
		pt_wd      = '0;
		tlb_we     = 1'b0;
		tlb_wa     = slot_q;
		tlb_wd     = {1'b1, vpn_q, pt_frame};
		done_go    = 1'b0;
		res_phys   = '0;
		res_status = ST_OK;
		res_hit    = 1'b0;
		acc_d      = acc_q;
		miss_d     = miss_q;
		case (state_q)
			S_CLEAR: begin
				pt_we  = (clr_q < CLR_W'(PAGES));
				pt_wa  = clr_q[VPAGE_WIDTH-1:0];
				tlb_we = (clr_q < CLR_W'(TLB_SLOTS));
				tlb_wa = clr_q[SLOT_W-1:0];
				tlb_wd = '0;
				if (clr_q == CLR_W'(NMAX - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					pt_re   = 1'b1;
					state_d = S_REM;
				end
			end
			S_REM: begin
				state_d = S_TLB;
			end
			S_TLB: begin
				tlb_re  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					done_go = 1'b1;
					state_d = S_IDLE;
					case (op_q)
						OP_TRANSLATE: begin
							acc_d = acc_q + COUNT_W'(1);
							if (!vpn_zero && tlb_match) begin
								res_hit  = 1'b1;
								res_phys = px_hit[PHYS_W-1:0];
							end else begin
								miss_d = miss_q + COUNT_W'(1);
								if (vpn_zero)
									res_status = ST_RESERVED;
								else if (!pt_valid)
									res_status = ST_NOT_MAPPED;
								else begin
									tlb_we   = 1'b1;
									res_phys = px_fill[PHYS_W-1:0];
								end
							end
						end
						OP_MAP: begin
							if (vpn_zero)
								res_status = ST_RESERVED;
							else if (pt_valid)
								res_status = ST_ALREADY;
							else begin
								pt_we = 1'b1;
								pt_wd = {1'b1, frame_in_q};
							end
						end
						OP_UNMAP: begin
							if (vpn_zero)
								res_status = ST_RESERVED;
							else if (!pt_valid)
								res_status = ST_NOT_MAPPED;
							else begin
								pt_we = 1'b1;
								// drop a stale TLB copy of this page
								if (tlb_match) begin
									tlb_we = 1'b1;
									tlb_wd = {1'b0, tlb_rd_q[TLB_W-2:0]};
								end
							end
						end
						default: begin
							// unused code: plain ok, nothing changes
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.paddr        = phys_q;
	assign rsp.status       = status_q;
	assign rsp.tlb_hit      = hit_q;
	assign rsp.access_count = acc_q;
	assign rsp.miss_count   = miss_q;

`ifndef ASSERT_OFF
	// a result only appears out of the decision cycle
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside decision cycle");

	// an accepted item starts slot arithmetic and blocks further requests
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_REM) && !req.ready)
		else $error("accepted item did not enter slot stage");

	// a miss is always also an access
	a_miss_with_access: assert property (@(posedge clk) disable iff (!arst_n)
		(miss_q != $past(miss_q)) |-> (acc_q != $past(acc_q)))
		else $error("miss counted without access");
`endif

endmodule

### dv/page_translate_with_tlb_unit_tb.sv
// ----------------------------------------------------------------------------
// page_translate_with_tlb_unit_tb: self-checking bench for the translation unit
// Directed rows cover the reserved page, faults, double maps, TLB fill, hit,
// slot conflict, unmap invalidation and the unused opcode, then a long random run
// on a small page pool. Results are checked against a predictor or a row's typed values.
// ----------------------------------------------------------------------------
module page_translate_with_tlb_unit_tb;
	import ptlb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Block configuration, kept at the defaults
	localparam int OFFSET_W = 12;
	localparam int VPAGE_W  = 12;
	localparam int FRAME_W  = 10;
	localparam int SLOTS    = 64;
	localparam int PAGES    = 1 << VPAGE_W;

	// The package enum has no member for the spare opcode
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int N_RANDOM    = 1850;
	localparam int QUIET_ITEMS = 150;   // tail of the run with no idling
	localparam int HOLD_AT     = 600;   // item count that starts the long rsp hold
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_AT    = 1200;  // item count where the sender drains
	localparam int POOL_PAGES  = 96;    // more pages than slots, so slots collide
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [PHYS_W-1:0]   phys;
		logic [STATUS_W-1:0] status;
		logic                hit;
		logic [COUNT_W-1:0]  accesses;
		logic [COUNT_W-1:0]  misses;
	} xlate_result_t;

	// One directed row; when known is set the listed result is checked as typed
	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [ADDR_W-1:0]     vaddr;
		logic [FRAME_IN_W-1:0] frame;
		logic                  known;
		logic [PHYS_W-1:0]     phys;
		logic [STATUS_W-1:0]   status;
		logic                  hit;
		logic [COUNT_W-1:0]    accesses;
		logic [COUNT_W-1:0]    misses;
	} stim_row_t;

	localparam int N_DIRECTED = 23;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// reserved page, every operation
		'{OP_TRANSLATE, 24'h000000, 10'h000, 1'b1, 22'h0, ST_RESERVED, 1'b0, 32'd1, 32'd1},
		'{OP_MAP,       24'h000ABC, 10'h3FF, 1'b1, 22'h0, ST_RESERVED, 1'b0, 32'd1, 32'd1},
		'{OP_UNMAP,     24'h000FFF, 10'h000, 1'b1, 22'h0, ST_RESERVED, 1'b0, 32'd1, 32'd1},
		// faults on an unmapped page
		'{OP_TRANSLATE, 24'h001FFF, 10'h000, 1'b1, 22'h0, ST_NOT_MAPPED, 1'b0, 32'd2, 32'd2},
		'{OP_UNMAP,     24'h001000, 10'h000, 1'b1, 22'h0, ST_NOT_MAPPED, 1'b0, 32'd2, 32'd2},
		// map, then map again
		'{OP_MAP,       24'h001000, 10'h3FF, 1'b1, 22'h0, ST_OK,      1'b0, 32'd2, 32'd2},
		'{OP_MAP,       24'h001234, 10'h005, 1'b1, 22'h0, ST_ALREADY, 1'b0, 32'd2, 32'd2},
		// miss and fill at top frame and offset, then hit
		'{OP_TRANSLATE, 24'h001FFF, 10'h000, 1'b1, 22'h3FFFFF, ST_OK, 1'b0, 32'd3, 32'd3},
		'{OP_TRANSLATE, 24'h001000, 10'h000, 1'b1, 22'h3FF000, ST_OK, 1'b1, 32'd4, 32'd3},
		// top page with frame zero
		'{OP_MAP,       24'hFFF000, 10'h000, 1'b1, 22'h0,      ST_OK, 1'b0, 32'd4, 32'd3},
		'{OP_TRANSLATE, 24'hFFFABC, 10'h000, 1'b1, 22'h000ABC, ST_OK, 1'b0, 32'd5, 32'd4},
		// page sharing slot 1 with page 1: eviction and refill
		'{OP_MAP,       24'h041000, 10'h155, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_TRANSLATE, 24'h041123, 10'h000, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_TRANSLATE, 24'h001800, 10'h000, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		// unmap drops the TLB copy as well
		'{OP_UNMAP,     24'h001555, 10'h000, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_TRANSLATE, 24'h001000, 10'h000, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		// spare opcode with all address and frame bits set
		'{OP_UNUSED,    24'hFFFFFF, 10'h3FF, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_TRANSLATE, 24'hFFF000, 10'h000, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_MAP,       24'hFFF000, 10'h2AA, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_UNMAP,     24'hFFF000, 10'h000, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_TRANSLATE, 24'hFFF000, 10'h000, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_MAP,       24'h800AAA, 10'h2AA, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0},
		'{OP_TRANSLATE, 24'h800555, 10'h000, 1'b0, 22'h0, ST_OK, 1'b0, 32'd0, 32'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	ptlb_req_if req ();
	ptlb_rsp_if rsp ();

	page_translate_with_tlb_unit #(
		.OFFSET_WIDTH(OFFSET_W),
		.VPAGE_WIDTH (VPAGE_W),
		.FRAME_WIDTH (FRAME_W),
		.TLB_SLOTS   (SLOTS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Predictor state: page table, TLB and counters
	logic               pt_valid [PAGES];
	logic [FRAME_W-1:0] pt_frame [PAGES];
	logic               tlb_valid [SLOTS];
	logic [VPAGE_W-1:0] tlb_tag   [SLOTS];
	logic [FRAME_W-1:0] tlb_frame [SLOTS];
	logic [COUNT_W-1:0] lookups_seen;
	logic [COUNT_W-1:0] lookups_missed;
	logic [COUNT_W-1:0] lookups_hit;

	xlate_result_t pending_results [$];

	// Typed result that travels alongside a directed item
	logic          known_flag;
	xlate_result_t known_result;

	int  mismatches;
	int  results_seen;
	int  hits_seen;
	int  faults_seen;
	int  reserved_seen;
	int  items_sent;
	int  cycle_count;
	logic quiet;

	always #6 clk = ~clk;

	// Work out the result of one item and advance the predictor state
	function automatic xlate_result_t compute_result(input logic [OP_W-1:0] op,
			input logic [ADDR_W-1:0] vaddr, input logic [FRAME_IN_W-1:0] frame_in);
		logic [OFFSET_W-1:0] offset;
		logic [VPAGE_W-1:0]  vpn;
		int                  slot;
		logic [FRAME_W-1:0]  fr;
		logic [63:0]         wide;
		xlate_result_t       res;

		offset = vaddr[OFFSET_W-1:0];
		vpn    = vaddr[OFFSET_W +: VPAGE_W];
		slot   = int'(vpn) % SLOTS;
		fr     = frame_in[FRAME_W-1:0];
		res    = '0;
		res.status = ST_OK;

		if (op == OP_TRANSLATE) begin
			lookups_seen = lookups_seen + 1;
			if (vpn != 0 && tlb_valid[slot] && tlb_tag[slot] == vpn) begin
				lookups_hit = lookups_hit + 1;
				res.hit  = 1'b1;
				wide     = (64'(tlb_frame[slot]) << OFFSET_W) | 64'(offset);
				res.phys = wide[PHYS_W-1:0];
			end else begin
				lookups_missed = lookups_missed + 1;
				if (vpn == 0) begin
					res.status = ST_RESERVED;
				end else if (!pt_valid[vpn]) begin
					res.status = ST_NOT_MAPPED;
				end else begin
					// fill the slot from the page table
					tlb_valid[slot] = 1'b1;
					tlb_tag[slot]   = vpn;
					tlb_frame[slot] = pt_frame[vpn];
					wide     = (64'(pt_frame[vpn]) << OFFSET_W) | 64'(offset);
					res.phys = wide[PHYS_W-1:0];
				end
			end
		end else if (op == OP_MAP) begin
			if (vpn == 0) begin
				res.status = ST_RESERVED;
			end else if (pt_valid[vpn]) begin
				res.status = ST_ALREADY;
			end else begin
				pt_valid[vpn] = 1'b1;
				pt_frame[vpn] = fr;
			end
		end else if (op == OP_UNMAP) begin
			if (vpn == 0) begin
				res.status = ST_RESERVED;
			end else if (!pt_valid[vpn]) begin
				res.status = ST_NOT_MAPPED;
			end else begin
				pt_valid[vpn] = 1'b0;
				if (tlb_valid[slot] && tlb_tag[slot] == vpn)
					tlb_valid[slot] = 1'b0;
			end
		end
		// spare opcode falls through with zero paddr, ok status and no hit; counters as they stand

		res.accesses = lookups_seen;
		res.misses   = lookups_missed;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
			$realtime, results_seen, what, got, want);
	endtask

	// Result checking first, then prediction of a newly accepted item, so a
	// result can never be matched against the item taken at the same edge.
	always @(posedge clk) begin : scoreboard
		xlate_result_t want;
		xlate_result_t fresh;

		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending, status", 64'(rsp.status), 64'h0);
				end else begin
					want = pending_results.pop_front();
					if (rsp.paddr !== want.phys)
						report_mismatch("paddr", 64'(rsp.paddr), 64'(want.phys));
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.tlb_hit !== want.hit)
						report_mismatch("tlb_hit", 64'(rsp.tlb_hit), 64'(want.hit));
					if (rsp.access_count !== want.accesses)
						report_mismatch("access_count", 64'(rsp.access_count), 64'(want.accesses));
					if (rsp.miss_count !== want.misses)
						report_mismatch("miss_count", 64'(rsp.miss_count), 64'(want.misses));
					if (want.hit)
						hits_seen++;
					if (want.status == ST_NOT_MAPPED)
						faults_seen++;
					if (want.status == ST_RESERVED)
						reserved_seen++;
				end
				results_seen++;
			end
			if (req.valid && req.ready) begin
				// the predictor always runs so its state follows the block
				fresh = compute_result(req.operation, req.vaddr, req.frame_number);
				if (known_flag)
					pending_results.push_back(known_result);
				else
					pending_results.push_back(fresh);
			end
		end
	end

	// Watchdog: covers the clearing pass after reset and the slowest run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: random stall bursts, one long hold-off to fill the block,
	// and a steady ready through the quiet tail.
	initial begin : result_sink
		int stall_left;
		int hold_left;
		bit hold_done;

		stall_left = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp.ready <= 1'b0;
			end else if (quiet) begin
				rsp.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Offer one item and wait for it to be taken. Called just after a rising
	// edge; valid stays high when items follow back to back.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] vaddr,
			input logic [FRAME_IN_W-1:0] frame, input logic known,
			input xlate_result_t res);
		req.valid        <= 1'b1;
		req.operation    <= op;
		req.vaddr        <= vaddr;
		req.frame_number <= frame;
		known_flag       <= known;
		known_result     <= res;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Random idle burst on the request side, skipped in the quiet tail
	task automatic request_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
	endtask

	initial begin : stimulus
		stim_row_t           row;
		xlate_result_t       res;
		logic [OP_W-1:0]     op;
		logic [VPAGE_W-1:0]  vpn;
		logic [ADDR_W-1:0]   vaddr;
		int                  pick;

		arst_n           <= 1'b0;
		req.valid        <= 1'b0;
		req.operation    <= OP_TRANSLATE;
		req.vaddr        <= '0;
		req.frame_number <= '0;
		known_flag       <= 1'b0;
		known_result     <= '0;
		quiet            = 1'b0;
		mismatches       = 0;
		results_seen     = 0;
		hits_seen        = 0;
		faults_seen      = 0;
		reserved_seen    = 0;
		items_sent       = 0;

		for (int i = 0; i < PAGES; i++) begin
			pt_valid[i] = 1'b0;
			pt_frame[i] = '0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			tlb_valid[i] = 1'b0;
			tlb_tag[i]   = '0;
			tlb_frame[i] = '0;
		end
		lookups_seen   = '0;
		lookups_missed = '0;
		lookups_hit    = '0;

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; ready stays low through the clearing pass, so the
		// first handshake also waits that out.
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED_ROWS[i];
			res.phys     = row.phys;
			res.status   = row.status;
			res.hit      = row.hit;
			res.accesses = row.accesses;
			res.misses   = row.misses;
			request_gap();
			send_item(row.op, row.vaddr, row.frame, row.known, res);
		end

		// Random part: mostly a small page pool so maps, hits, conflicts and
		// unmaps meet each other; some pages anywhere and the odd reserved one.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - QUIET_ITEMS)
				quiet = 1'b1;

			if (items_sent == DRAIN_AT) begin
				// sender pause until every pending result is back
				req.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end

			pick = $urandom_range(0, 99);
			if (pick < 52)
				op = OP_TRANSLATE;
			else if (pick < 74)
				op = OP_MAP;
			else if (pick < 96)
				op = OP_UNMAP;
			else
				op = OP_UNUSED;

			pick = $urandom_range(0, 99);
			if (pick < 5)
				vpn = '0;
			else if (pick < 72)
				vpn = VPAGE_W'($urandom_range(1, POOL_PAGES));
			else
				vpn = VPAGE_W'($urandom_range(0, PAGES - 1));

			vaddr = {vpn, OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1))};
			request_gap();
			send_item(op, vaddr, FRAME_IN_W'($urandom_range(0, (1 << FRAME_IN_W) - 1)),
				1'b0, '0);
		end

		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		// a few more cycles to catch any stray result
		repeat (12)
			@(posedge clk);

		$display("%0d items, %0d results checked: %0d TLB hits, %0d page faults, %0d reserved",
			items_sent, results_seen, hits_seen, faults_seen, reserved_seen);
		$display("predictor totals: %0d lookups, %0d misses, %0d hits",
			lookups_seen, lookups_missed, lookups_hit);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/ptlb_pkg.sv
hw/rtl/ptlb_req_if.sv
hw/rtl/ptlb_rsp_if.sv
hw/rtl/page_translate_with_tlb_unit.sv
dv/page_translate_with_tlb_unit_tb.sv
